/* hw/rtl/salr_pkg.sv */
// ----------------------------------------------------------------------------
// salr_pkg: shared types and constants
// Command codes, fixed-point constants and widths for the arc-length resampler.
// ----------------------------------------------------------------------------
`default_nettype none
package salr_pkg;
   localparam int unsigned LenW = 40;
   localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
   localparam logic [16:0] OneQ16 = 17'h10000;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;
endpackage
`default_nettype wire

/* hw/rtl/spline_arc_length_resampler_core.sv */
// ----------------------------------------------------------------------------
// spline_arc_length_resampler_core
// Loads cubic segments into a table and resamples them at equal arc length.
// ----------------------------------------------------------------------------
// Operation: load and clear update the table; a sample on an empty table gives
//   a zero result with status set. Other samples divide for s, search the
//   cumulative lengths (read and compare states), read the previous length,
//   divide for t (skipped on a zero length), then form the cubics and result.
// Throughput: one word at a time; a finished sample holds in ST_DONE while the
//   result register is full. Reset: synchronous; zeroes count, total; num_samples=2.
`default_nettype none
module spline_arc_length_resampler_core
   import salr_pkg::*;
#(
   parameter int unsigned MAX_SEGMENTS = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_num_samples,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [31:0] req_x_coef0,
   input  wire logic signed [31:0] req_x_coef1,
   input  wire logic signed [31:0] req_x_coef2,
   input  wire logic signed [31:0] req_x_coef3,
   input  wire logic signed [31:0] req_y_coef0,
   input  wire logic signed [31:0] req_y_coef1,
   input  wire logic signed [31:0] req_y_coef2,
   input  wire logic signed [31:0] req_y_coef3,
   input  wire logic [31:0]        req_seg_length,
   input  wire logic [15:0]        req_sample_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_x_pos,
   output logic signed [31:0]      rsp_y_pos,
   output logic [7:0]              rsp_segment,
   output logic [16:0]             rsp_t_frac,
   output logic [39:0]             rsp_arc_pos,
   output logic                    rsp_status
);
   localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

   // Segment memory: coefficients, segment length, cumulative length.
   localparam int unsigned EW = 256 + 32 + LenW;
   logic [EW-1:0] seg_mem [MAX_SEGMENTS];
   logic [EW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seg_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= seg_mem[rd_addr];
   end

   wire logic [LenW-1:0] rd_cum = rd_data_ff[LenW-1:0];
   wire logic [31:0]     rd_len = rd_data_ff[LenW+31:LenW];

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_S, ST_SRCH_RD, ST_SRCH_CMP, ST_PREV_RD, ST_PREV_GET,
      ST_DIV_T, ST_POW2, ST_POW3, ST_TERM, ST_DONE
   } state_type;

   state_type       state_ff;
   logic [CW-1:0]   seg_count_ff;
   logic [LenW-1:0] total_len_ff;
   logic [15:0]     num_samples_ff;
   // Shared restoring divider: quotient/dividend register and remainder.
   logic [55:0]     quo_ff;
   logic [32:0]     rem_ff;
   logic [16:0]     div_ff;
   logic [5:0]      cnt_ff;
   logic [LenW-1:0] s_ff;
   logic [CW-1:0]   lo_ff, hi_ff, mid_ff;
   logic [AW-1:0]   seg_ff;
   logic [LenW-1:0] prev_ff;
   logic [255:0]    coef_ff;
   logic [31:0]     len_ff;
   logic [16:0]     t_ff;
   logic [16:0]     t2_ff, t3_ff;
   logic [2:0]      term_ff;
   logic signed [33:0] xacc_ff, yacc_ff;
   logic            empty_ff;
   logic            rsp_valid_ff;
   logic signed [31:0] x_out_ff, y_out_ff;
   logic [7:0]      seg_out_ff;
   logic [16:0]     t_out_ff;
   logic [39:0]     arc_out_ff;
   logic            status_ff;
   logic [33:0]     prod_ff;
   logic signed [49:0] term_prod_ff;
   logic            tp_valid_ff;
   logic            tp_isy_ff;

   wire cmd_type cmd = cmd_type'(req_cmd);
   wire logic req_fire = req_valid && req_ready;
   // A waiting result does not block the input; ST_DONE holds instead.
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // Load path writes at the current count.
   wire logic load_ok = req_fire && (cmd == CMD_LOAD) &&
                        (seg_count_ff < CW'(MAX_SEGMENTS));
   wire logic [LenW:0] len_sum = {1'b0, total_len_ff} + {9'd0, req_seg_length};
   wire logic [LenW-1:0] len_sat = len_sum[LenW] ? LenMax : len_sum[LenW-1:0];
   assign wr_en   = load_ok;
   assign wr_addr = seg_count_ff[AW-1:0];
   assign wr_data = {req_y_coef3, req_y_coef2, req_y_coef1, req_y_coef0,
                     req_x_coef3, req_x_coef2, req_x_coef1, req_x_coef0,
                     req_seg_length, len_sat};

   always_comb begin
      case (state_ff)
         ST_PREV_RD: rd_addr = AW'(seg_ff - AW'(1));
         ST_SRCH_RD: rd_addr = mid_ff[AW-1:0];
         default:    rd_addr = seg_ff;
      endcase
   end

   // Divider step: shift one dividend bit into the remainder.
   wire logic [33:0] trial_s = {rem_ff, quo_ff[55]} - {17'd0, div_ff};
   wire logic [33:0] trial_t = {rem_ff, quo_ff[55]} - {2'd0, len_ff};

   // Term select for the multiply sequence.
   logic signed [31:0] tc;
   logic [16:0]        tv;
   always_comb begin
      case (term_ff[1:0])
         2'd0:    tv = t_ff;
         2'd1:    tv = t2_ff;
         default: tv = t3_ff;
      endcase
      case ({term_ff[2], term_ff[1:0]})
         3'd0:    tc = coef_ff[63:32];
         3'd1:    tc = coef_ff[95:64];
         3'd2:    tc = coef_ff[127:96];
         3'd4:    tc = coef_ff[191:160];
         3'd5:    tc = coef_ff[223:192];
         default: tc = coef_ff[255:224];
      endcase
   end

   // Arithmetic shift is floor for signed values.
   wire logic signed [33:0] term_sh = 34'(term_prod_ff >>> 16);
   wire logic signed [33:0] xsum = xacc_ff + term_sh;
   wire logic signed [33:0] ysum = yacc_ff + term_sh;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647)       return 32'sh7FFFFFFF;
      else if (v < -34'sd2147483648) return 32'sh80000000;
      else                           return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         seg_count_ff   <= '0;
         total_len_ff   <= '0;
         num_samples_ff <= 16'd2;
         rsp_valid_ff   <= 1'b0;
         tp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) num_samples_ff <= csr_num_samples;
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (cmd)
                     CMD_CLEAR: begin
                        seg_count_ff <= '0;
                        total_len_ff <= '0;
                     end
                     CMD_LOAD: begin
                        if (load_ok) begin
                           seg_count_ff <= seg_count_ff + CW'(1);
                           total_len_ff <= len_sat;
                        end
                     end
                     CMD_SAMPLE: begin
                        if (seg_count_ff == '0) begin
                           // Empty table: all-zero result with status set.
                           xacc_ff <= '0; yacc_ff <= '0; seg_ff <= '0;
                           t_ff <= '0; s_ff <= '0; empty_ff <= 1'b1;
                           state_ff <= ST_DONE;
                        end else begin
                           // idx * total fits in 56 bits.
                           quo_ff <= 56'(req_sample_index * total_len_ff);
                           rem_ff <= '0;
                           div_ff <= (num_samples_ff > 16'd1) ?
                                     {1'b0, num_samples_ff - 16'd1} : 17'd1;
                           cnt_ff <= 6'd0;
                           empty_ff <= 1'b0;
                           state_ff <= ST_DIV_S;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_DIV_S: begin
               if (!trial_s[33]) begin
                  rem_ff <= trial_s[32:0];
                  quo_ff <= {quo_ff[54:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[31:0], quo_ff[55]};
                  quo_ff <= {quo_ff[54:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd55) begin
                  state_ff <= ST_SRCH_RD;
                  lo_ff <= '0;
                  hi_ff <= seg_count_ff - CW'(1);
                  mid_ff <= CW'((seg_count_ff - CW'(1)) >> 1);
               end
            end
            ST_SRCH_RD: begin
               if (cnt_ff == 6'd56) begin
                  cnt_ff <= 6'd0;
                  s_ff <= (quo_ff[55:LenW] != '0) ? LenMax : quo_ff[LenW-1:0];
               end
               state_ff <= ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
               // Find first j with cum[j] > s in [lo, hi]; hi is the clamp.
               if (lo_ff == hi_ff) begin
                  seg_ff <= lo_ff[AW-1:0];
                  state_ff <= (lo_ff == '0) ? ST_PREV_GET : ST_PREV_RD;
                  prev_ff <= '0;
               end else begin
                  // Midpoint sums carry one extra bit.
                  if (rd_cum > s_ff) begin
                     hi_ff <= mid_ff;
                     mid_ff <= CW'(({1'b0, lo_ff} + {1'b0, mid_ff}) >> 1);
                  end else begin
                     lo_ff <= mid_ff + CW'(1);
                     mid_ff <= CW'(({1'b0, mid_ff} + {1'b0, hi_ff} + (CW+1)'(1)) >> 1);
                  end
                  state_ff <= ST_SRCH_RD;
               end
            end
            ST_PREV_RD: state_ff <= ST_PREV_GET;
            ST_PREV_GET: begin
               if (seg_ff != '0) prev_ff <= rd_cum;
               state_ff <= ST_DIV_T;
               cnt_ff <= 6'd0;
            end
            ST_DIV_T: begin
               if (cnt_ff == 6'd0) begin
                  // Entry read for seg_ff now available.
                  coef_ff <= rd_data_ff[EW-1:32+LenW];
                  len_ff  <= rd_len;
                  xacc_ff <= 34'(signed'(rd_data_ff[32+LenW+31:32+LenW]));
                  yacc_ff <= 34'(signed'(rd_data_ff[32+LenW+159:32+LenW+128]));
                  rem_ff  <= '0;
                  if (rd_len == '0 || s_ff < prev_ff) begin
                     t_ff <= OneQ16;
                     state_ff <= ST_POW2;
                  end else begin
                     quo_ff <= {s_ff - prev_ff, 16'd0};
                     cnt_ff <= 6'd1;
                  end
               end else begin
                  if (!trial_t[33]) begin
                     rem_ff <= trial_t[32:0];
                     quo_ff <= {quo_ff[54:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[31:0], quo_ff[55]};
                     quo_ff <= {quo_ff[54:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff == 6'd56) state_ff <= ST_POW2;
               end
            end
            ST_POW2: begin
               if (cnt_ff == 6'd57) begin
                  t_ff <= (quo_ff[55:17] != '0 || quo_ff[16:0] > OneQ16) ?
                          OneQ16 : quo_ff[16:0];
                  cnt_ff <= 6'd0;
               end else begin
                  prod_ff <= t_ff * t_ff;
                  state_ff <= ST_POW3;
               end
            end
            ST_POW3: begin
               if (cnt_ff == 6'd0) begin
                  t2_ff <= prod_ff[32:16];
                  prod_ff <= prod_ff[32:16] * t_ff;
                  cnt_ff <= 6'd1;
               end else begin
                  t3_ff <= prod_ff[32:16];
                  term_ff <= 3'd0;
                  tp_valid_ff <= 1'b0;
                  state_ff <= ST_TERM;
               end
            end
            ST_TERM: begin
               // Multiply one term a cycle; accumulate the prior one.
               if (tp_valid_ff) begin
                  if (tp_isy_ff) yacc_ff <= ysum;
                  else           xacc_ff <= xsum;
               end
               if (term_ff == 3'd7) begin
                  tp_valid_ff <= 1'b0;
                  state_ff <= ST_DONE;
               end else begin
                  term_prod_ff <= tc * signed'({1'b0, tv});
                  tp_isy_ff <= term_ff[2];
                  tp_valid_ff <= 1'b1;
                  term_ff <= (term_ff == 3'd2) ? 3'd4 :
                             (term_ff == 3'd6) ? 3'd7 : term_ff + 3'd1;
               end
            end
            ST_DONE: begin
               // Wait here until the result register is free.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  x_out_ff <= sat32(xacc_ff);
                  y_out_ff <= sat32(yacc_ff);
                  seg_out_ff <= 8'(seg_ff);
                  t_out_ff <= t_ff;
                  arc_out_ff <= s_ff;
                  status_ff <= empty_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_pos   = x_out_ff;
   assign rsp_y_pos   = y_out_ff;
   assign rsp_segment = seg_out_ff;
   assign rsp_t_frac  = t_out_ff;
   assign rsp_arc_pos = arc_out_ff;
   assign rsp_status  = status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff <= CW'(MAX_SEGMENTS)) else $error("segment count overflow");
   a_t_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_t_frac <= OneQ16) else $error("t out of range");
   a_busy_noreq: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status) |-> (rsp_x_pos == '0 && rsp_arc_pos == '0))
      else $error("empty status with data");
`endif
endmodule
`default_nettype wire
